@@ design/fcrq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcrq_pkg
// Shared codes, record layout and handshake structs for the frame capture
// ring queue.
// ----------------------------------------------------------------------------
package fcrq_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int STAMP_W  = 63;
    localparam int LEN_W    = 12;
    localparam int CNT_W    = 32;

    // request commands
    localparam logic [CMD_W-1:0] CMD_ARRIVAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RECORD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

    localparam logic [1:0]       TYPE_MISC     = 2'd3;
    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 12'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [STAMP_W-1:0] timestamp_us;
        logic signed [7:0]  rssi;
        logic [7:0]         channel;
        logic [1:0]         packet_type;
        logic [LEN_W-1:0]   dump_length;
        logic [LEN_W-1:0]   signal_length;
        logic [7:0]         receive_state;
    } item_t;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic signed [7:0]  rssi;
        logic [7:0]         channel;
        logic [1:0]         ptype;
        logic [LEN_W-1:0]   orig_len;
        logic [LEN_W-1:0]   cap_len;
    } record_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;          // execute the request presented this cycle
        logic load_record;   // capture RAM read data into the result
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_read;     // presented request is a poll on a non-empty ring
    } dp_status_t;

endpackage
`default_nettype wire

@@ design/fcrq_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcrq_req_if / fcrq_rsp_if
// Valid/ready channels carrying requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface fcrq_req_if
    import fcrq_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [STAMP_W-1:0] timestamp_us;
    logic signed [7:0]  rssi;
    logic [7:0]         channel;
    logic [1:0]         packet_type;
    logic [LEN_W-1:0]   dump_length;
    logic [LEN_W-1:0]   signal_length;
    logic [7:0]         receive_state;

    modport source (output valid, command, timestamp_us, rssi, channel, packet_type,
                    dump_length, signal_length, receive_state, input ready);
    modport sink   (input valid, command, timestamp_us, rssi, channel, packet_type,
                    dump_length, signal_length, receive_state, output ready);
endinterface

interface fcrq_rsp_if
    import fcrq_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [STAMP_W-1:0]  record_time;
    logic signed [7:0]   record_rssi;
    logic [7:0]          record_channel;
    logic [1:0]          record_type;
    logic [LEN_W-1:0]    original_length;
    logic [LEN_W-1:0]    captured_length;
    logic [CNT_W-1:0]    received_total;
    logic [CNT_W-1:0]    dropped_total;
    logic [CNT_W-1:0]    byte_total;

    modport source (output valid, status, record_time, record_rssi, record_channel,
                    record_type, original_length, captured_length, received_total,
                    dropped_total, byte_total, input ready);
    modport sink   (input valid, status, record_time, record_rssi, record_channel,
                    record_type, original_length, captured_length, received_total,
                    dropped_total, byte_total, output ready);
endinterface
`default_nettype wire

@@ design/fcrq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcrq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/fcrq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcrq_datapath
// Ring pointers, counters, record RAM and result register.
// ----------------------------------------------------------------------------
module fcrq_datapath
    import fcrq_pkg::*;
#(
    parameter int QUEUE_SLOTS   = 32,
    parameter int SNAPSHOT_SIZE = 128
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_en,
    input  wire logic                cfg_write_data,
    input  wire item_t               item,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               sts,
    output logic [STATUS_W-1:0]      status,
    output record_t                  record,
    output logic [CNT_W-1:0]         received_total,
    output logic [CNT_W-1:0]         dropped_total,
    output logic [CNT_W-1:0]         byte_total
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
    localparam logic [LEN_W-1:0] SNAP_LEN  = LEN_W'(SNAPSHOT_SIZE);

    logic                capture_en_reg;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    recv_reg, recv_next;
    logic [CNT_W-1:0]    drop_reg, drop_next;
    logic [CNT_W-1:0]    byte_reg, byte_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    record_t             record_reg;
    record_t             wr_record;
    record_t             rd_record;

    logic [LEN_W-1:0] frame_len;
    logic             frame_ok;
    logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
    logic             ring_full, ring_empty;
    logic             ram_wr, ram_rd;

    always_comb
    begin
        frame_len  = (item.dump_length != '0) ? item.dump_length : item.signal_length;
        frame_ok   = capture_en_reg && (item.packet_type != TYPE_MISC)
                     && (item.receive_state == '0) && (frame_len >= MIN_FRAME_LEN);
        wr_ptr_inc = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PTR_W'(1);
        rd_ptr_inc = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PTR_W'(1);
        ring_full  = (wr_ptr_inc == rd_ptr_reg);
        ring_empty = (rd_ptr_reg == wr_ptr_reg);

        wr_record.stamp    = item.timestamp_us;
        wr_record.rssi     = item.rssi;
        wr_record.channel  = item.channel;
        wr_record.ptype    = item.packet_type;
        wr_record.orig_len = frame_len;
        wr_record.cap_len  = (frame_len < SNAP_LEN) ? frame_len : SNAP_LEN;

        sts.need_read = (item.command == CMD_POLL) && !ring_empty;
        ram_rd        = cmd.exec && sts.need_read;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        recv_next   = recv_reg;
        drop_next   = drop_reg;
        byte_next   = byte_reg;
        status_next = ST_IGNORED;
        ram_wr      = 1'b0;
        case (item.command)
            CMD_ARRIVAL:
            begin
                if (frame_ok)
                begin
                    recv_next = recv_reg + CNT_W'(1);
                    byte_next = byte_reg + CNT_W'(frame_len);
                    if (ring_full)
                    begin
                        drop_next   = drop_reg + CNT_W'(1);
                        status_next = ST_DROPPED;
                    end
                    else
                    begin
                        ram_wr      = cmd.exec;
                        wr_ptr_next = wr_ptr_inc;
                        status_next = ST_STORED;
                    end
                end
            end
            CMD_POLL:
            begin
                if (!ring_empty)
                begin
                    rd_ptr_next = rd_ptr_inc;
                    status_next = ST_RECORD;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            CMD_RESTART:
            begin
                wr_ptr_next = '0;
                rd_ptr_next = '0;
                recv_next   = '0;
                drop_next   = '0;
                byte_next   = '0;
                status_next = ST_CLEARED;
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_en_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            recv_reg       <= '0;
            drop_reg       <= '0;
            byte_reg       <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                capture_en_reg <= cfg_write_data;
            end
            if (cmd.exec)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                recv_reg   <= recv_next;
                drop_reg   <= drop_next;
                byte_reg   <= byte_next;
            end
        end
    end

    // result payload: zero record now, fill from RAM in the next cycle on a hit
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            record_reg <= '0;
        end
        else if (cmd.load_record)
        begin
            record_reg <= rd_record;
        end
    end

    fcrq_ram #(
        .WIDTH ($bits(record_t)),
        .DEPTH (QUEUE_SLOTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_record),
        .rd_en   (ram_rd),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_record)
    );

    assign status         = status_reg;
    assign record         = record_reg;
    assign received_total = recv_reg;
    assign dropped_total  = drop_reg;
    assign byte_total     = byte_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && item.command == CMD_RESTART) |=>
        (wr_ptr_reg == '0 && rd_ptr_reg == '0 && recv_reg == '0
         && drop_reg == '0 && byte_reg == '0))
        else $error("restart left pointers or counters set");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg <= LAST_SLOT) && (rd_ptr_reg <= LAST_SLOT))
        else $error("ring pointer beyond last slot");

    a_drop_holds_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && status_next == ST_DROPPED) |=> $stable(wr_ptr_reg))
        else $error("dropped frame moved the write pointer");

endmodule
`default_nettype wire

@@ design/fcrq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fcrq_ctrl
// Handshake controller: accepts requests, waits out RAM reads, presents results.
// ----------------------------------------------------------------------------
module fcrq_ctrl
    import fcrq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_READ:  in_ready = 1'b0;
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
            end
            default: in_ready = 1'b0;
        endcase
        in_fire         = in_valid && in_ready;
        cmd.exec        = in_fire;
        cmd.load_record = (state_reg == S_READ);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = sts.need_read ? S_READ : S_OUT;
                end
            end
            S_READ: state_next = S_OUT;
            S_OUT:
            begin
                if (in_fire)
                begin
                    state_next = sts.need_read ? S_READ : S_OUT;
                end
                else if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_follows_poll: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(cmd.exec && sts.need_read))
        else $error("read wait entered without a polling hit");

endmodule
`default_nettype wire

@@ design/frame_capture_ring_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// frame_capture_ring_queue
// Circular queue of received-frame metadata with received, dropped and byte
// counters.
// ----------------------------------------------------------------------------
// Usage:
//   request : valid/ready channel; each request carries a command - frame
//             arrival, poll the oldest record, or restart (clear pointers and
//             counters). Accepted when valid and ready are both high.
//   result  : valid/ready channel; exactly one result per request, giving the
//             status, the popped record (zero unless a record was returned)
//             and the three 32-bit counters after the request.
//   cfg     : cfg_write_en/cfg_write_data write capture_enable; write it only
//             while the queue is idle.
//   Timing  : a result is valid in the cycle after acceptance, but a poll that
//             returns a record waits in S_READ for the registered read of the record RAM.
//   Rate    : one request per cycle back to back while results are taken at
//             once; a returning poll holds the next request off for the RAM read.
//   Stall   : a result waiting on the receiver holds; the next request is only
//             taken in the cycle the waiting result goes out.
//   Reset   : pointers, counters and capture_enable clear; RAM contents are
//             left as they are and only read back after being written.
// ----------------------------------------------------------------------------
module frame_capture_ring_queue
    import fcrq_pkg::*;
#(
    parameter int QUEUE_SLOTS   = 32,
    parameter int SNAPSHOT_SIZE = 128
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cfg_write_en,
    input  wire logic   cfg_write_data,
    fcrq_req_if.sink    request,
    fcrq_rsp_if.source  result
);

    item_t      item;
    ctrl_cmd_t  cmd;
    dp_status_t sts;
    record_t    record;

    // gather the request fields into one item for the datapath
    always_comb
    begin
        item.command       = request.command;
        item.timestamp_us  = request.timestamp_us;
        item.rssi          = request.rssi;
        item.channel       = request.channel;
        item.packet_type   = request.packet_type;
        item.dump_length   = request.dump_length;
        item.signal_length = request.signal_length;
        item.receive_state = request.receive_state;
    end

    fcrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fcrq_datapath #(
        .QUEUE_SLOTS   (QUEUE_SLOTS),
        .SNAPSHOT_SIZE (SNAPSHOT_SIZE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item           (item),
        .cmd            (cmd),
        .sts            (sts),
        .status         (result.status),
        .record         (record),
        .received_total (result.received_total),
        .dropped_total  (result.dropped_total),
        .byte_total     (result.byte_total)
    );

    // unpack the held record onto the result channel
    assign result.record_time     = record.stamp;
    assign result.record_rssi     = record.rssi;
    assign result.record_channel  = record.channel;
    assign result.record_type     = record.ptype;
    assign result.original_length = record.orig_len;
    assign result.captured_length = record.cap_len;

endmodule
`default_nettype wire
